>>> rtl/flpf_pkg.sv
// ----------------------------------------------------------------------------
// flpf_pkg
// Types and constants shared by the four-level priority FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package flpf_pkg;

  localparam int NUM_LEVELS = 4;
  localparam int LVL_W      = 2;
  localparam int CAP_W      = 11;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int OUT_USER_W = 6;
  localparam int IN_USER_W  = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_CAP_L0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_L1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_L2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_L3 = 8'd3;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [LVL_W-1:0]  level;
    logic              all_empty;
    logic              all_full;
    logic              from_mem;
  } meta_t;

endpackage

`default_nettype wire

>>> rtl/flpf_ram.sv
// ----------------------------------------------------------------------------
// flpf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module flpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/flpf_ctrl.sv
// ----------------------------------------------------------------------------
// flpf_ctrl
// Per-level head, tail and fill tracking, capacity registers, level select
// and entry store access for one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module flpf_ctrl #(
  parameter int LEVEL_DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_valid,
  input  wire logic [flpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [flpf_pkg::CAP_W-1:0]            cfg_data,
  input  wire logic                                  go,
  input  wire flpf_pkg::opcode_t                     opcode,
  input  wire logic [flpf_pkg::LVL_W-1:0]            level,
  input  wire logic [flpf_pkg::VAL_W-1:0]            item_value,
  output logic                                       mem_wr_en,
  output logic [flpf_pkg::LVL_W+$clog2(LEVEL_DEPTH)-1:0] mem_wr_addr,
  output logic [flpf_pkg::VAL_W-1:0]                 mem_wr_data,
  output logic                                       mem_rd_en,
  output logic [flpf_pkg::LVL_W+$clog2(LEVEL_DEPTH)-1:0] mem_rd_addr,
  output flpf_pkg::meta_t                            meta
);

  localparam int IDX_W = $clog2(LEVEL_DEPTH);
  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam int NL    = flpf_pkg::NUM_LEVELS;

  logic [flpf_pkg::CAP_W-1:0] cap_r   [NL];
  logic [IDX_W-1:0]           head_r  [NL];
  logic [IDX_W-1:0]           head_nxt[NL];
  logic [IDX_W-1:0]           tail_r  [NL];
  logic [IDX_W-1:0]           tail_nxt[NL];
  logic [CNT_W-1:0]           cnt_r   [NL];
  logic [CNT_W-1:0]           cnt_nxt [NL];
  logic [CNT_W-1:0]           eff_cap [NL];
  logic [NL-1:0]              full;
  logic [NL-1:0]              full_nxt;
  logic [NL-1:0]              empty_nxt;
  logic                       deq_hit;
  logic [flpf_pkg::LVL_W-1:0] deq_lvl;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] cap);
    logic [IDX_W:0] inc;
    inc = {1'b0, idx} + (IDX_W+1)'(1);
    if (32'(inc) >= 32'(cap)) begin
      return '0;
    end
    return inc[IDX_W-1:0];
  endfunction

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (cap_r[l] == '0) begin
        eff_cap[l] = CNT_W'(1);
      end else if (32'(cap_r[l]) > LEVEL_DEPTH) begin
        eff_cap[l] = CNT_W'(LEVEL_DEPTH);
      end else begin
        eff_cap[l] = CNT_W'(cap_r[l]);
      end
      full[l] = cnt_r[l] >= eff_cap[l];
    end
  end

  always_comb begin
    deq_hit = 1'b0;
    deq_lvl = '0;
    for (int l = 0; l < NL; l++) begin
      if (cnt_r[l] != '0) begin
        deq_hit = 1'b1;
        deq_lvl = flpf_pkg::LVL_W'(l);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      head_nxt[l] = head_r[l];
      tail_nxt[l] = tail_r[l];
      cnt_nxt[l]  = cnt_r[l];
    end
    mem_wr_en   = 1'b0;
    mem_wr_addr = {level, tail_r[level]};
    mem_wr_data = item_value;
    mem_rd_en   = 1'b0;
    mem_rd_addr = {deq_lvl, head_r[deq_lvl]};
    meta.status   = flpf_pkg::ST_OK;
    meta.level    = '0;
    meta.from_mem = 1'b0;

    if (opcode == flpf_pkg::OP_ENQ) begin
      meta.level = level;
      if (full[level]) begin
        meta.status = flpf_pkg::ST_FULL;
      end else begin
        mem_wr_en       = go;
        tail_nxt[level] = advance(tail_r[level], eff_cap[level]);
        cnt_nxt[level]  = cnt_r[level] + CNT_W'(1);
      end
    end else begin
      if (deq_hit) begin
        mem_rd_en         = go;
        meta.level        = deq_lvl;
        meta.from_mem     = 1'b1;
        head_nxt[deq_lvl] = advance(head_r[deq_lvl], eff_cap[deq_lvl]);
        cnt_nxt[deq_lvl]  = cnt_r[deq_lvl] - CNT_W'(1);
      end else begin
        meta.status = flpf_pkg::ST_EMPTY;
      end
    end

    for (int l = 0; l < NL; l++) begin
      empty_nxt[l] = cnt_nxt[l] == '0;
      full_nxt[l]  = cnt_nxt[l] >= eff_cap[l];
    end
    meta.all_empty = &empty_nxt;
    meta.all_full  = &full_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NL; l++) begin
        cap_r[l]  <= flpf_pkg::CAP_RESET;
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      if (go) begin
        for (int l = 0; l < NL; l++) begin
          head_r[l] <= head_nxt[l];
          tail_r[l] <= tail_nxt[l];
          cnt_r[l]  <= cnt_nxt[l];
        end
      end
      if (cfg_valid) begin
        case (cfg_index)
          flpf_pkg::CFG_CAP_L0: cap_r[0] <= cfg_data;
          flpf_pkg::CFG_CAP_L1: cap_r[1] <= cfg_data;
          flpf_pkg::CFG_CAP_L2: cap_r[2] <= cfg_data;
          flpf_pkg::CFG_CAP_L3: cap_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/four_level_priority_fifo_top.sv
// ----------------------------------------------------------------------------
// four_level_priority_fifo_top
// Four priority levels of circular FIFO sharing one entry store RAM.
// Pending register holds an accepted beat until the output register is free.
// Throughput: one beat per cycle while output flows; up to one store access per beat.
// Output register holds a finished result while the next beat is taken.
// Reset: synchronous, active low; clears indices, counts and the pending and output
// valid flags, loads every capacity with 1024. The entry store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_priority_fifo_top #(
  parameter int LEVEL_DEPTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [flpf_pkg::VAL_W-1:0]          in_tdata,  // item_value
  input  wire logic [flpf_pkg::IN_USER_W-1:0]      in_tuser,  // opcode, level
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [flpf_pkg::VAL_W-1:0]          out_tdata, // out_value
  output logic      [flpf_pkg::OUT_USER_W-1:0]     out_tuser, // status, out_level,
                                                               // all_empty, all_full
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [flpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [flpf_pkg::CAP_W-1:0]          cfg_data
);

  localparam int IDX_W  = $clog2(LEVEL_DEPTH);
  localparam int ADDR_W = flpf_pkg::LVL_W + IDX_W;
  localparam int DEPTH  = flpf_pkg::NUM_LEVELS << IDX_W;

  logic                         go;
  logic                         out_free;
  logic                         mem_wr_en;
  logic [ADDR_W-1:0]            mem_wr_addr;
  logic [flpf_pkg::VAL_W-1:0]   mem_wr_data;
  logic                         mem_rd_en;
  logic [ADDR_W-1:0]            mem_rd_addr;
  logic [flpf_pkg::VAL_W-1:0]   mem_rd_data;
  flpf_pkg::meta_t              meta;
  flpf_pkg::meta_t              pend_meta_r;
  logic                         pend_r;
  logic                         out_valid_r;
  logic [flpf_pkg::VAL_W-1:0]   out_data_r;
  logic [flpf_pkg::OUT_USER_W-1:0] out_user_r;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = !pend_r || out_free;
  assign go         = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  flpf_ctrl #(
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .go          (go),
    .opcode      (flpf_pkg::opcode_t'(in_tuser[0])),
    .level       (in_tuser[2:1]),
    .item_value  (in_tdata),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .meta        (meta)
  );

  flpf_ram #(
    .WIDTH (flpf_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (go) begin
      pend_meta_r <= meta;
    end
    if (pend_r && out_free) begin
      out_data_r <= pend_meta_r.from_mem ? mem_rd_data : '0;
      out_user_r <= {pend_meta_r.all_full, pend_meta_r.all_empty,
                     pend_meta_r.level, pend_meta_r.status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        pend_r <= 1'b1;
      end else if (out_free) begin
        pend_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= pend_r;
      end
    end
  end

endmodule

`default_nettype wire

>>> bench/four_level_priority_fifo_top_tb.sv
// ----------------------------------------------------------------------------
// four_level_priority_fifo_top_tb
// Self-checking bench for the four-level priority FIFO. A shadow copy of
// the four circular queues predicts status, value, level and the all-empty
// and all-full flags of every beat. Directed cases cover the extremes, and
// random traffic runs under several capacity settings and idling patterns.
// ----------------------------------------------------------------------------
module four_level_priority_fifo_top_tb;
  import flpf_pkg::*;

  localparam int          LEVEL_DEPTH    = 1024;
  localparam int          CLK_PERIOD     = 20;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] value;
    logic [LVL_W-1:0] level;
    logic             all_empty;
    logic             all_full;
  } queue_outcome_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [VAL_W-1:0]      in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [VAL_W-1:0]      out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CAP_W-1:0]      cfg_data   = '0;

  logic [VAL_W-1:0] shadow_store [NUM_LEVELS][LEVEL_DEPTH];
  int unsigned      level_head [NUM_LEVELS];
  int unsigned      level_tail [NUM_LEVELS];
  int unsigned      level_fill [NUM_LEVELS];
  logic [CAP_W-1:0] cap_shadow [NUM_LEVELS];

  queue_outcome_t outcomes_due[$];

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned error_count;
  int unsigned beats_sent;
  int unsigned outcomes_checked;
  int unsigned drops_seen;
  int unsigned empty_pops;
  int unsigned all_full_hits;

  four_level_priority_fifo_top #(.LEVEL_DEPTH(LEVEL_DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int unsigned level_limit(int unsigned lvl);
    int unsigned c;
    c = cap_shadow[lvl];
    if (c == 0) c = 1;
    if (c > LEVEL_DEPTH) c = LEVEL_DEPTH;
    return c;
  endfunction

  function automatic int unsigned next_slot(int unsigned idx, int unsigned lim);
    return (idx + 1 >= lim) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned total_fill();
    int unsigned sum;
    sum = 0;
    for (int l = 0; l < NUM_LEVELS; l++) sum += level_fill[l];
    return sum;
  endfunction

  function automatic void reset_shadow();
    for (int l = 0; l < NUM_LEVELS; l++) begin
      level_head[l] = 0;
      level_tail[l] = 0;
      level_fill[l] = 0;
      cap_shadow[l] = CAP_RESET;
    end
  endfunction

  function automatic void apply_queue_op(opcode_t op, logic [LVL_W-1:0] lvl,
                                         logic [VAL_W-1:0] val);
    queue_outcome_t r;
    bit served;
    r.status    = ST_OK;
    r.value     = '0;
    r.level     = lvl;
    r.all_empty = 1'b1;
    r.all_full  = 1'b1;
    served      = 1'b0;
    if (op == OP_ENQ) begin
      if (level_fill[lvl] >= level_limit(lvl)) begin
        r.status = ST_FULL;
        drops_seen++;
      end else begin
        shadow_store[lvl][level_tail[lvl]] = val;
        level_tail[lvl] = next_slot(level_tail[lvl], level_limit(lvl));
        level_fill[lvl]++;
      end
    end else begin
      r.status = ST_EMPTY;
      r.level  = '0;
      for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
        if (!served && level_fill[k] != 0) begin
          served = 1'b1;
          r.value  = shadow_store[k][level_head[k]];
          r.level  = LVL_W'(k);
          r.status = ST_OK;
          level_head[k] = next_slot(level_head[k], level_limit(k));
          level_fill[k]--;
        end
      end
      if (!served) empty_pops++;
    end
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (level_fill[l] != 0) r.all_empty = 1'b0;
      if (level_fill[l] < level_limit(l)) r.all_full = 1'b0;
    end
    if (r.all_full) all_full_hits++;
    outcomes_due.push_back(r);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  always begin : result_checker
    queue_outcome_t got;
    queue_outcome_t want;
    @(negedge clk);
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got.status    = status_t'(out_tuser[1:0]);
      got.level     = out_tuser[3:2];
      got.all_empty = out_tuser[4];
      got.all_full  = out_tuser[5];
      got.value     = out_tdata;
      @(posedge clk);
      outcomes_checked++;
      if (outcomes_due.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        want = outcomes_due.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.value !== want.value)
          report_mismatch($sformatf("value %h, want %h", got.value, want.value));
        if (got.level !== want.level)
          report_mismatch($sformatf("level %0d, want %0d", got.level, want.level));
        if (got.all_empty !== want.all_empty)
          report_mismatch($sformatf("all_empty %b, want %b", got.all_empty,
                                    want.all_empty));
        if (got.all_full !== want.all_full)
          report_mismatch($sformatf("all_full %b, want %b", got.all_full,
                                    want.all_full));
      end
    end
  end

  task automatic send_beat(input opcode_t op, input logic [LVL_W-1:0] lvl,
                           input logic [VAL_W-1:0] val);
    logic taken;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {lvl, op};
    in_tdata  <= val;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (taken !== 1'b1);
    beats_sent++;
    apply_queue_op(op, lvl, val);
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outcomes_due.size() != 0);
  endtask

  task automatic set_caps(input logic [CAP_W-1:0] c0, input logic [CAP_W-1:0] c1,
                          input logic [CAP_W-1:0] c2, input logic [CAP_W-1:0] c3,
                          input bit poke_unmapped);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [CAP_W-1:0]     val [5];
    logic                 taken;
    idx = '{CFG_CAP_L0, CFG_CAP_L1, CFG_CAP_L2, CFG_CAP_L3, CFG_UNMAPPED};
    val = '{c0, c1, c2, c3, 11'd5};
    for (int i = 0; i < (poke_unmapped ? 5 : 4); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do begin
        @(negedge clk);
        taken = cfg_ready;
        @(posedge clk);
      end while (taken !== 1'b1);
      case (idx[i])
        CFG_CAP_L0: cap_shadow[0] = val[i];
        CFG_CAP_L1: cap_shadow[1] = val[i];
        CFG_CAP_L2: cap_shadow[2] = val[i];
        CFG_CAP_L3: cap_shadow[3] = val[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_levels();
    while (total_fill() != 0) send_beat(OP_DEQ, LVL_W'($urandom), $urandom);
  endtask

  function automatic logic [CAP_W-1:0] pick_cap();
    int unsigned r;
    r = $urandom_range(19);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return CAP_RESET;
      3:       return CAP_W'($urandom_range(7, 40));
      default: return CAP_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '1;
      1:       return {1'b1, {(VAL_W-1){1'b0}}};
      2:       return {1'b0, {(VAL_W-1){1'b1}}};
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_dequeue();
    send_beat(OP_DEQ, 2'd3, 32'hFFFF_FFFF);
    wait_results_done();
  endtask

  task automatic test_directed_cases();
    set_caps(11'd0, 11'd2, 11'd1, 11'd1, 1'b1);
    send_beat(OP_ENQ, 2'd0, 32'h7FFF_FFFF);
    send_beat(OP_ENQ, 2'd0, 32'h1234_5678);
    send_beat(OP_ENQ, 2'd1, 32'hFFFF_FFFF);
    send_beat(OP_ENQ, 2'd1, 32'h8000_0000);
    send_beat(OP_ENQ, 2'd1, 32'h0000_0001);
    send_beat(OP_ENQ, 2'd2, 32'h0000_0000);
    send_beat(OP_ENQ, 2'd3, 32'hFFFF_FFFF);
    send_beat(OP_ENQ, 2'd3, 32'hA5A5_A5A5);
    send_beat(OP_DEQ, 2'd0, 32'hDEAD_BEEF);
    send_beat(OP_DEQ, 2'd1, 32'h0);
    send_beat(OP_DEQ, 2'd2, 32'h0);
    send_beat(OP_DEQ, 2'd3, 32'h0);
    send_beat(OP_DEQ, 2'd0, 32'h0);
    send_beat(OP_DEQ, 2'd0, 32'h0);
    send_beat(OP_ENQ, 2'd0, 32'h0000_00AA);
    send_beat(OP_ENQ, 2'd2, 32'h0000_00BB);
    send_beat(OP_DEQ, 2'd0, 32'h0);
    send_beat(OP_DEQ, 2'd0, 32'h0);
    send_beat(OP_DEQ, 2'd1, 32'h0);
    wait_results_done();
  endtask

  task automatic test_large_capacity();
    drain_levels();
    wait_results_done();
    set_caps(11'h7FF, CAP_RESET, CAP_RESET, CAP_RESET, 1'b0);
    for (int i = 0; i <= LEVEL_DEPTH; i++) send_beat(OP_ENQ, 2'd0, $urandom);
    send_beat(OP_ENQ, 2'd2, pick_value());
    send_beat(OP_DEQ, 2'd0, $urandom);
    for (int i = 0; i < 3; i++) send_beat(OP_DEQ, 2'd3, $urandom);
    for (int i = 0; i < 3; i++) send_beat(OP_ENQ, 2'd0, $urandom);
    wait_results_done();
  endtask

  task automatic test_random_traffic(input int unsigned gap, input int unsigned stall);
    int unsigned enq_pct [3];
    opcode_t     op;
    enq_pct   = '{35, 55, 72};
    gap_pct   = gap;
    stall_pct = stall;
    for (int r = 0; r < 3; r++) begin
      drain_levels();
      wait_results_done();
      set_caps(pick_cap(), pick_cap(), pick_cap(), pick_cap(), 1'b0);
      for (int i = 0; i < 30; i++) begin
        op = ($urandom_range(99) < enq_pct[r]) ? OP_ENQ : OP_DEQ;
        send_beat(op, LVL_W'($urandom), pick_value());
        if ($urandom_range(99) == 0) wait_results_done();
      end
    end
  endtask

  initial begin
    error_count      = 0;
    beats_sent       = 0;
    outcomes_checked = 0;
    drops_seen       = 0;
    empty_pops       = 0;
    all_full_hits    = 0;
    gap_pct          = 31;
    stall_pct        = 52;
    reset_shadow();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_dequeue();
    test_directed_cases();
    test_random_traffic(31, 52);
    test_random_traffic(52, 31);
    test_random_traffic(0, 0);
    test_large_capacity();
    wait_results_done();
    repeat (4) @(posedge clk);

    $display("Covered %0d beats, %0d results checked, capacities 0 to 2047.",
             beats_sent, outcomes_checked);
    $display("Saw %0d full drops, %0d empty dequeues, %0d all-full results.",
             drops_seen, empty_pops, all_full_hits);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d results outstanding", outcomes_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> four_level_priority_fifo_top.f
rtl/flpf_pkg.sv
rtl/flpf_ram.sv
rtl/flpf_ctrl.sv
rtl/four_level_priority_fifo_top.sv
bench/four_level_priority_fifo_top_tb.sv
